>>> rtl/psw_pkg.sv
package psw_pkg;

    // stream widths
    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 24;

    // event selector
    localparam logic [2:0] ACT_TICK    = 3'd0;
    localparam logic [2:0] ACT_CREATE  = 3'd1;
    localparam logic [2:0] ACT_TERM    = 3'd2;
    localparam logic [2:0] ACT_SLEEP   = 3'd3;
    localparam logic [2:0] ACT_WAIT    = 3'd4;
    localparam logic [2:0] ACT_RESCHED = 3'd5;

    // process states kept in the table (unused is a flop bit)
    localparam logic [2:0] ST_READY    = 3'd1;
    localparam logic [2:0] ST_RUNNING  = 3'd2;
    localparam logic [2:0] ST_SLEEPING = 3'd3;
    localparam logic [2:0] ST_WAITING  = 3'd4;

    // lists
    localparam logic [1:0] LST_READY = 2'd0;
    localparam logic [1:0] LST_SLEEP = 2'd1;
    localparam logic [1:0] LST_WAIT  = 2'd2;

    // status codes
    localparam logic [1:0] RC_OK          = 2'd0;
    localparam logic [1:0] RC_CREATE_FAIL = 2'd1;
    localparam logic [1:0] RC_NO_CHILD    = 2'd2;

    // configuration register indexes and reset values
    localparam logic [1:0] CFG_SLICE       = 2'd0;
    localparam logic [1:0] CFG_MAX_ROUNDS  = 2'd1;
    localparam logic [1:0] CFG_INIT_ROUNDS = 2'd2;
    localparam logic [15:0] SLICE_RST      = 16'd10;
    localparam logic [7:0]  MAX_ROUNDS_RST = 8'd3;
    localparam logic [7:0]  INIT_ROUNDS_RST = 8'd0;

    typedef struct packed {
        logic [15:0] slice_ticks;
        logic [7:0]  max_rounds;
        logic [7:0]  initial_rounds;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  action;
        logic        image_ok;
        logic [15:0] sleep_ticks;
    } req_t;

    // packed lowest field last so it lands in the low bits of tdata
    typedef struct packed {
        logic       reschedule_request;
        logic [4:0] parent_id;
        logic [3:0] new_id;
        logic [1:0] status_code;
        logic       switched;
        logic       cpu_idle;
        logic [3:0] running_id;
    } res_t;

endpackage

>>> rtl/psw_ctrl.sv
module psw_ctrl import psw_pkg::*; #(
    parameter int PROCESS_COUNT = 16
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic start,
    input  req_t req,
    input  cfg_t cfg,
    output logic idle,
    output logic res_valid,
    output res_t res,
    input  logic res_ready
);

    localparam int ID_W  = $clog2(PROCESS_COUNT);
    localparam int PTR_W = ID_W + 1;
    localparam int CNT_W = ID_W + 1;
    localparam logic [PTR_W-1:0] P_NONE = '1;
    localparam logic [PTR_W-1:0] P_COUNT = PTR_W'(PROCESS_COUNT);

    typedef struct packed {
        logic [2:0]       status;
        logic [15:0]      slice;
        logic [7:0]       rounds;
        logic [15:0]      sleep_left;
        logic [PTR_W-1:0] parent;
        logic [CNT_W-1:0] children;
        logic [PTR_W-1:0] next;
    } rec_t;

    typedef enum logic [28:0] {
        S_IDLE    = 29'b1 << 0,
        S_DISP    = 29'b1 << 1,
        S_TK_CUR  = 29'b1 << 2,
        S_TK_NEXT = 29'b1 << 3,
        S_TK_EVAL = 29'b1 << 4,
        S_WK_PUSH = 29'b1 << 5,
        S_WK_SEC  = 29'b1 << 6,
        S_WR_REC  = 29'b1 << 7,
        S_PT      = 29'b1 << 8,
        S_LN_RD   = 29'b1 << 9,
        S_LN_WR   = 29'b1 << 10,
        S_DR_A    = 29'b1 << 11,
        S_DR_B    = 29'b1 << 12,
        S_LV      = 29'b1 << 13,
        S_LV2     = 29'b1 << 14,
        S_CR_SCAN = 29'b1 << 15,
        S_CR_PAR  = 29'b1 << 16,
        S_TM_A    = 29'b1 << 17,
        S_TM_B    = 29'b1 << 18,
        S_TM_C    = 29'b1 << 19,
        S_SC_A    = 29'b1 << 20,
        S_SC_B    = 29'b1 << 21,
        S_SL_A    = 29'b1 << 22,
        S_WT_A    = 29'b1 << 23,
        S_RS_A    = 29'b1 << 24,
        S_FIN     = 29'b1 << 25,
        S_FN_B    = 29'b1 << 26,
        S_FN_C    = 29'b1 << 27,
        S_OUT     = 29'b1 << 28
    } state_t;

    // process table
    rec_t rec_mem [PROCESS_COUNT];
    rec_t mem_q_reg;
    logic mem_re, mem_we;
    logic [ID_W-1:0] mem_ra, mem_wa;
    rec_t mem_wd;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            rec_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            mem_q_reg <= rec_mem[mem_ra];
        end
    end

    state_t state_reg, state_next;
    state_t rec_ret_reg, rec_ret_next, drop_ret_reg, drop_ret_next, lnk_ret_reg, lnk_ret_next;
    logic [PROCESS_COUNT-1:0] used_reg, used_next;
    logic [PTR_W-1:0] cur_reg, cur_next, old_reg, old_next;
    logic [2:0][PTR_W-1:0] hd_reg, hd_next, tl_reg, tl_next;
    logic pend_reg, pend_next;
    req_t rq_reg, rq_next;
    rec_t rec_reg, rec_next;
    logic [ID_W-1:0] rec_id_reg, rec_id_next;
    logic [1:0] lsel_reg, lsel_next, lv_list_reg, lv_list_next;
    logic [2:0] lv_st_reg, lv_st_next;
    logic [PTR_W-1:0] wk_cur_reg, wk_cur_next, wk_prev_reg, wk_prev_next;
    logic [ID_W-1:0] lnk_addr_reg, lnk_addr_next;
    logic [PTR_W-1:0] lnk_val_reg, lnk_val_next;
    logic [PTR_W-1:0] tk_p_reg, tk_p_next;
    logic [ID_W-1:0] term_id_reg, term_id_next;
    logic [PTR_W-1:0] par_reg, par_next;
    logic [PTR_W-1:0] scan_reg, scan_next;
    logic [1:0] code_reg, code_next;
    logic [ID_W-1:0] newid_reg, newid_next;
    logic rreq_reg, rreq_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            used_reg  <= '0;
            cur_reg   <= P_NONE;
            hd_reg    <= {3{P_NONE}};
            tl_reg    <= {3{P_NONE}};
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            used_reg  <= used_next;
            cur_reg   <= cur_next;
            hd_reg    <= hd_next;
            tl_reg    <= tl_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        rec_ret_reg  <= rec_ret_next;
        drop_ret_reg <= drop_ret_next;
        lnk_ret_reg  <= lnk_ret_next;
        old_reg      <= old_next;
        rq_reg       <= rq_next;
        rec_reg      <= rec_next;
        rec_id_reg   <= rec_id_next;
        lsel_reg     <= lsel_next;
        lv_list_reg  <= lv_list_next;
        lv_st_reg    <= lv_st_next;
        wk_cur_reg   <= wk_cur_next;
        wk_prev_reg  <= wk_prev_next;
        lnk_addr_reg <= lnk_addr_next;
        lnk_val_reg  <= lnk_val_next;
        tk_p_reg     <= tk_p_next;
        term_id_reg  <= term_id_next;
        par_reg      <= par_next;
        scan_reg     <= scan_next;
        code_reg     <= code_next;
        newid_reg    <= newid_next;
        rreq_reg     <= rreq_next;
    end

    always_comb begin
        rec_t q;
        logic run;
        logic [ID_W-1:0] cur_id, scan_id;
        logic [15:0] dec16;
        logic [7:0] r8;
        logic [CNT_W-1:0] ch;
        logic [17:0] s3;

        q       = mem_q_reg;
        run     = !cur_reg[ID_W];
        cur_id  = cur_reg[ID_W-1:0];
        scan_id = scan_reg[ID_W-1:0];
        dec16   = '0;
        r8      = '0;
        ch      = '0;
        s3      = {2'b00, cfg.slice_ticks} + {1'b0, cfg.slice_ticks, 1'b0};

        state_next    = state_reg;
        rec_ret_next  = rec_ret_reg;
        drop_ret_next = drop_ret_reg;
        lnk_ret_next  = lnk_ret_reg;
        used_next     = used_reg;
        cur_next      = cur_reg;
        old_next      = old_reg;
        hd_next       = hd_reg;
        tl_next       = tl_reg;
        pend_next     = pend_reg;
        rq_next       = rq_reg;
        rec_next      = rec_reg;
        rec_id_next   = rec_id_reg;
        lsel_next     = lsel_reg;
        lv_list_next  = lv_list_reg;
        lv_st_next    = lv_st_reg;
        wk_cur_next   = wk_cur_reg;
        wk_prev_next  = wk_prev_reg;
        lnk_addr_next = lnk_addr_reg;
        lnk_val_next  = lnk_val_reg;
        tk_p_next     = tk_p_reg;
        term_id_next  = term_id_reg;
        par_next      = par_reg;
        scan_next     = scan_reg;
        code_next     = code_reg;
        newid_next    = newid_reg;
        rreq_next     = rreq_reg;

        mem_re = 1'b0;
        mem_ra = '0;
        mem_we = 1'b0;
        mem_wa = '0;
        mem_wd = q;
        res_valid = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (start) begin
                    rq_next    = req;
                    old_next   = cur_reg;
                    code_next  = RC_OK;
                    newid_next = '0;
                    rreq_next  = 1'b0;
                    state_next = S_DISP;
                end
            end

            S_DISP: begin
                state_next = S_FIN;
                mem_ra = cur_id;
                case (rq_reg.action)
                    ACT_TICK: begin
                        tk_p_next = hd_reg[LST_SLEEP];
                        mem_re = run;
                        state_next = run ? S_TK_CUR : S_TK_NEXT;
                    end
                    ACT_CREATE: begin
                        if (!rq_reg.image_ok) begin
                            code_next = RC_CREATE_FAIL;
                        end else begin
                            scan_next  = '0;
                            state_next = S_CR_SCAN;
                        end
                    end
                    ACT_TERM: begin
                        mem_re = run;
                        if (run) state_next = S_TM_A;
                    end
                    ACT_SLEEP: begin
                        mem_re = run;
                        if (run) state_next = S_SL_A;
                    end
                    ACT_WAIT: begin
                        mem_re = run;
                        if (run) state_next = S_WT_A;
                    end
                    ACT_RESCHED: begin
                        if (pend_reg) begin
                            pend_next = 1'b0;
                            mem_re = run;
                            if (run) state_next = S_RS_A;
                        end
                    end
                    default: begin
                        state_next = S_FIN;
                    end
                endcase
            end

            // running slice countdown
            S_TK_CUR: begin
                dec16 = (q.slice == 16'd0) ? 16'd0 : q.slice - 16'd1;
                mem_we = 1'b1;
                mem_wa = cur_id;
                mem_wd.slice = dec16;
                if (dec16 == 16'd0) begin
                    pend_next = 1'b1;
                    rreq_next = 1'b1;
                end
                state_next = S_TK_NEXT;
            end

            // sleep list walk
            S_TK_NEXT: begin
                if (tk_p_reg[ID_W]) begin
                    state_next = S_FIN;
                end else begin
                    mem_re = 1'b1;
                    mem_ra = tk_p_reg[ID_W-1:0];
                    state_next = S_TK_EVAL;
                end
            end

            S_TK_EVAL: begin
                dec16 = (q.sleep_left == 16'd0) ? 16'd0 : q.sleep_left - 16'd1;
                tk_p_next = q.next;
                if (dec16 != 16'd0) begin
                    mem_we = 1'b1;
                    mem_wa = tk_p_reg[ID_W-1:0];
                    mem_wd.sleep_left = dec16;
                    state_next = S_TK_NEXT;
                end else begin
                    rec_next = q;
                    rec_next.sleep_left = 16'd0;
                    rec_next.status = ST_READY;
                    rec_id_next   = tk_p_reg[ID_W-1:0];
                    lsel_next     = LST_SLEEP;
                    wk_cur_next   = hd_reg[LST_SLEEP];
                    wk_prev_next  = P_NONE;
                    drop_ret_next = S_WK_PUSH;
                    rec_ret_next  = S_TK_NEXT;
                    state_next    = S_DR_A;
                end
            end

            // wakeup: second in the ready queue (head if it is empty) with slice left, else tail with full slice
            S_WK_PUSH: begin
                lsel_next = LST_READY;
                if (rec_reg.slice != 16'd0) begin
                    if (hd_reg[LST_READY][ID_W]) begin
                        hd_next[LST_READY] = {1'b0, rec_id_reg};
                        tl_next[LST_READY] = {1'b0, rec_id_reg};
                        rec_next.next = P_NONE;
                        state_next = S_WR_REC;
                    end else begin
                        mem_re = 1'b1;
                        mem_ra = hd_reg[LST_READY][ID_W-1:0];
                        state_next = S_WK_SEC;
                    end
                end else begin
                    rec_next.slice = cfg.slice_ticks;
                    state_next = S_PT;
                end
            end

            S_WK_SEC: begin
                rec_next.next = q.next;
                mem_we = 1'b1;
                mem_wa = hd_reg[LST_READY][ID_W-1:0];
                mem_wd.next = {1'b0, rec_id_reg};
                if (tl_reg[LST_READY] == hd_reg[LST_READY]) begin
                    tl_next[LST_READY] = {1'b0, rec_id_reg};
                end
                state_next = S_WR_REC;
            end

            S_WR_REC: begin
                mem_we = 1'b1;
                mem_wa = rec_id_reg;
                mem_wd = rec_reg;
                state_next = rec_ret_reg;
            end

            // append held entry to list lsel
            S_PT: begin
                rec_next.next = P_NONE;
                tl_next[lsel_reg] = {1'b0, rec_id_reg};
                if (hd_reg[lsel_reg][ID_W] || tl_reg[lsel_reg][ID_W]) begin
                    hd_next[lsel_reg] = {1'b0, rec_id_reg};
                    state_next = S_WR_REC;
                end else begin
                    lnk_addr_next = tl_reg[lsel_reg][ID_W-1:0];
                    lnk_val_next  = {1'b0, rec_id_reg};
                    lnk_ret_next  = S_WR_REC;
                    state_next    = S_LN_RD;
                end
            end

            // next-pointer update of another entry
            S_LN_RD: begin
                mem_re = 1'b1;
                mem_ra = lnk_addr_reg;
                state_next = S_LN_WR;
            end

            S_LN_WR: begin
                mem_we = 1'b1;
                mem_wa = lnk_addr_reg;
                mem_wd.next = lnk_val_reg;
                state_next = lnk_ret_reg;
            end

            // unlink held entry from list lsel
            S_DR_A: begin
                if (wk_cur_reg[ID_W]) begin
                    state_next = drop_ret_reg;
                end else if (wk_cur_reg[ID_W-1:0] == rec_id_reg) begin
                    if (tl_reg[lsel_reg] == wk_cur_reg) begin
                        tl_next[lsel_reg] = wk_prev_reg;
                    end
                    if (wk_prev_reg[ID_W]) begin
                        hd_next[lsel_reg] = rec_reg.next;
                        state_next = drop_ret_reg;
                    end else begin
                        lnk_addr_next = wk_prev_reg[ID_W-1:0];
                        lnk_val_next  = rec_reg.next;
                        lnk_ret_next  = drop_ret_reg;
                        state_next    = S_LN_RD;
                    end
                end else begin
                    mem_re = 1'b1;
                    mem_ra = wk_cur_reg[ID_W-1:0];
                    state_next = S_DR_B;
                end
            end

            S_DR_B: begin
                wk_prev_next = wk_cur_reg;
                wk_cur_next  = q.next;
                state_next   = S_DR_A;
            end

            // running process leaves the ready queue for list lv_list
            S_LV: begin
                lsel_next     = LST_READY;
                wk_cur_next   = hd_reg[LST_READY];
                wk_prev_next  = P_NONE;
                drop_ret_next = S_LV2;
                state_next    = S_DR_A;
            end

            S_LV2: begin
                rec_next.status = lv_st_reg;
                cur_next     = P_NONE;
                lsel_next    = lv_list_reg;
                rec_ret_next = S_FIN;
                state_next   = S_PT;
            end

            S_CR_SCAN: begin
                if (scan_reg == P_COUNT) begin
                    code_next  = RC_CREATE_FAIL;
                    state_next = S_FIN;
                end else if (!used_reg[scan_id]) begin
                    used_next[scan_id] = 1'b1;
                    rec_next.status     = ST_READY;
                    rec_next.slice      = cfg.slice_ticks;
                    rec_next.rounds     = cfg.initial_rounds;
                    rec_next.sleep_left = 16'd0;
                    rec_next.parent     = run ? cur_reg : P_NONE;
                    rec_next.children   = '0;
                    rec_next.next       = P_NONE;
                    rec_id_next  = scan_id;
                    newid_next   = scan_id;
                    lsel_next    = LST_READY;
                    rec_ret_next = S_FIN;
                    mem_re = run;
                    mem_ra = cur_id;
                    state_next = run ? S_CR_PAR : S_PT;
                end else begin
                    scan_next = scan_reg + PTR_W'(1);
                end
            end

            S_CR_PAR: begin
                mem_we = 1'b1;
                mem_wa = cur_id;
                mem_wd.children = (q.children == '1) ? q.children : q.children + CNT_W'(1);
                state_next = S_PT;
            end

            S_TM_A: begin
                rec_next      = q;
                rec_id_next   = cur_id;
                term_id_next  = cur_id;
                par_next      = q.parent;
                lsel_next     = LST_READY;
                wk_cur_next   = hd_reg[LST_READY];
                wk_prev_next  = P_NONE;
                drop_ret_next = S_TM_B;
                state_next    = S_DR_A;
            end

            // a parent that is the terminated entry itself counts as unused
            S_TM_B: begin
                cur_next = P_NONE;
                used_next[term_id_reg] = 1'b0;
                scan_next = '0;
                if (!par_reg[ID_W] && used_reg[par_reg[ID_W-1:0]]
                        && par_reg[ID_W-1:0] != term_id_reg) begin
                    mem_re = 1'b1;
                    mem_ra = par_reg[ID_W-1:0];
                    state_next = S_TM_C;
                end else begin
                    state_next = S_SC_A;
                end
            end

            // parent loses a child, wakes when it waited and has none left
            S_TM_C: begin
                ch = (q.children == '0) ? '0 : q.children - CNT_W'(1);
                if (ch == '0 && q.status == ST_WAITING) begin
                    rec_next = q;
                    rec_next.children = ch;
                    rec_next.status   = ST_READY;
                    rec_id_next   = par_reg[ID_W-1:0];
                    lsel_next     = LST_WAIT;
                    wk_cur_next   = hd_reg[LST_WAIT];
                    wk_prev_next  = P_NONE;
                    drop_ret_next = S_WK_PUSH;
                    rec_ret_next  = S_SC_A;
                    state_next    = S_DR_A;
                end else begin
                    mem_we = 1'b1;
                    mem_wa = par_reg[ID_W-1:0];
                    mem_wd.children = ch;
                    state_next = S_SC_A;
                end
            end

            // orphans go to parent 0
            S_SC_A: begin
                if (scan_reg == P_COUNT) begin
                    state_next = S_FIN;
                end else if (used_reg[scan_id]) begin
                    mem_re = 1'b1;
                    mem_ra = scan_id;
                    state_next = S_SC_B;
                end else begin
                    scan_next = scan_reg + PTR_W'(1);
                end
            end

            S_SC_B: begin
                if (q.parent == {1'b0, term_id_reg}) begin
                    mem_we = 1'b1;
                    mem_wa = scan_id;
                    mem_wd.parent = '0;
                end
                scan_next  = scan_reg + PTR_W'(1);
                state_next = S_SC_A;
            end

            S_SL_A: begin
                rec_next = q;
                rec_next.sleep_left = rq_reg.sleep_ticks;
                rec_id_next  = cur_id;
                lv_list_next = LST_SLEEP;
                lv_st_next   = ST_SLEEPING;
                state_next   = S_LV;
            end

            S_WT_A: begin
                if (q.children != '0) begin
                    rec_next     = q;
                    rec_id_next  = cur_id;
                    lv_list_next = LST_WAIT;
                    lv_st_next   = ST_WAITING;
                    state_next   = S_LV;
                end else begin
                    code_next  = RC_NO_CHILD;
                    state_next = S_FIN;
                end
            end

            S_RS_A: begin
                if (q.next[ID_W]) begin
                    mem_we = 1'b1;
                    mem_wa = cur_id;
                    mem_wd.slice = cfg.slice_ticks;
                    state_next = S_FIN;
                end else begin
                    r8 = (q.rounds == 8'hFF) ? 8'hFF : q.rounds + 8'd1;
                    rec_next    = q;
                    rec_id_next = cur_id;
                    if (r8 >= cfg.max_rounds) begin
                        rec_next.rounds     = cfg.initial_rounds;
                        rec_next.sleep_left = s3[17:2];
                        lv_list_next = LST_SLEEP;
                        lv_st_next   = ST_SLEEPING;
                    end else begin
                        rec_next.rounds = r8;
                        rec_next.slice  = {1'b0, cfg.slice_ticks[15:1]};
                        lv_list_next = LST_READY;
                        lv_st_next   = ST_READY;
                    end
                    state_next = S_LV;
                end
            end

            // dispatch the ready head when nothing runs
            S_FIN: begin
                if (!run && !hd_reg[LST_READY][ID_W]) begin
                    mem_re = 1'b1;
                    mem_ra = hd_reg[LST_READY][ID_W-1:0];
                    state_next = S_FN_B;
                end else begin
                    state_next = S_FN_C;
                end
            end

            S_FN_B: begin
                mem_we = 1'b1;
                mem_wa = hd_reg[LST_READY][ID_W-1:0];
                mem_wd.status = ST_RUNNING;
                cur_next = hd_reg[LST_READY];
                state_next = S_FN_C;
            end

            S_FN_C: begin
                if (cur_reg != old_reg) pend_next = 1'b0;
                mem_re = run;
                mem_ra = cur_id;
                state_next = S_OUT;
            end

            S_OUT: begin
                res_valid = 1'b1;
                if (res_ready) state_next = S_IDLE;
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign idle = (state_reg == S_IDLE);

    always_comb begin
        logic [ID_W+4:0] run_ext, new_ext, par_ext;
        logic run;
        run     = !cur_reg[ID_W];
        run_ext = {5'b0, cur_reg[ID_W-1:0]};
        new_ext = {5'b0, newid_reg};
        par_ext = {5'b0, mem_q_reg.parent[ID_W-1:0]};
        res.running_id  = run ? run_ext[3:0] : 4'd0;
        res.cpu_idle    = !run;
        res.switched    = (cur_reg != old_reg);
        res.status_code = code_reg;
        res.new_id      = new_ext[3:0];
        res.parent_id   = (run && !mem_q_reg.parent[ID_W]) ? par_ext[4:0] : 5'h1F;
        res.reschedule_request = rreq_reg;
    end

    a_cur_used: assert property (@(posedge aclk) disable iff (!aresetn)
        !cur_reg[ID_W] |-> used_reg[cur_reg[ID_W-1:0]])
        else $error("running process not in use");

    a_cur_head: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE && !cur_reg[ID_W]) |-> hd_reg[LST_READY] == cur_reg)
        else $error("running process not at ready head");

    a_idle_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE && cur_reg[ID_W]) |-> hd_reg[LST_READY][ID_W])
        else $error("idle with ready process queued");

endmodule

>>> rtl/psw_out.sv
module psw_out import psw_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    input  res_t                 in_res,
    output logic                 in_ready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata
);

    logic vld_reg, vld_next;
    res_t data_reg, data_next;

    assign in_ready = !vld_reg || m_tready;

    always_comb begin
        vld_next  = vld_reg;
        data_next = data_reg;
        if (in_valid && in_ready) begin
            vld_next  = 1'b1;
            data_next = in_res;
        end else if (m_tready) begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign m_tvalid = vld_reg;
    assign m_tdata  = M_TDATA_W'(data_reg);

endmodule

>>> rtl/process_scheduler_slice_sleep_wait.sv
// task scheduler over a table of PROCESS_COUNT processes
// input requests arrive on the s_ stream: s_tuser carries the event
// (tick, create, terminate, sleep, wait for children, reschedule), s_tdata
// carries the sleep length and the create image flag
// every request gives exactly one result on the m_ stream: running process,
// idle flag, switch flag, status code, created id, parent and the
// reschedule request raised by a tick
// per-process state lives in one table memory (one read, one write port,
// registered read); each event is a read-modify-write sequence on it
// create scans the table entries ahead of the free one; a tick walks
// every sleeping process and the sleep list again for each wakeup;
// terminate scans all table entries for orphans; the one memory read
// port sets the pace of all these walks
// one request is worked at a time; the next is taken once the result sits
// in the output register, so a stalled receiver blocks only after one
// result waits there and another is finished
// reset (synchronous, active low) empties the table and all lists, clears
// the pending reschedule and loads the default configuration
// configuration is to be written through cfg_we/cfg_index/cfg_data only
// while idle; the block itself does not enforce this
module process_scheduler_slice_sleep_wait import psw_pkg::*; #(
    parameter int PROCESS_COUNT = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // sleep_ticks[15:0], image_ok[16]
    input  logic [S_TUSER_W-1:0] s_tuser,  // action[2:0]
    // result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // running_id[3:0], cpu_idle[4], switched[5], status_code[7:6],
    // new_id[11:8], parent_id[16:12], reschedule_request[17]
    output logic [M_TDATA_W-1:0] m_tdata,
    // configuration write port
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [15:0]          cfg_data
);

    cfg_t cfg_reg, cfg_next;
    req_t req;
    res_t res;
    logic ctrl_idle, res_valid, res_ready, start;

    // configuration registers
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_index)
                CFG_SLICE:       cfg_next.slice_ticks    = cfg_data;
                CFG_MAX_ROUNDS:  cfg_next.max_rounds     = cfg_data[7:0];
                CFG_INIT_ROUNDS: cfg_next.initial_rounds = cfg_data[7:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.slice_ticks    <= SLICE_RST;
            cfg_reg.max_rounds     <= MAX_ROUNDS_RST;
            cfg_reg.initial_rounds <= INIT_ROUNDS_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // request unpacking
    assign req.action      = s_tuser[2:0];
    assign req.sleep_ticks = s_tdata[15:0];
    assign req.image_ok    = s_tdata[16];

    // a request is taken only while the sequencer is idle
    assign s_tready = ctrl_idle;
    assign start    = s_tvalid && s_tready;

    psw_ctrl #(
        .PROCESS_COUNT(PROCESS_COUNT)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (start),
        .req       (req),
        .cfg       (cfg_reg),
        .idle      (ctrl_idle),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (res_ready)
    );

    // output register decouples the receiver
    psw_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (res_valid),
        .in_res   (res),
        .in_ready (res_ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
